@@ sv/rcs_pkg.sv @@
// Shared types and constants for the RGB contrast stretch block.
`timescale 1ns / 1ps
`default_nettype none

package rcs_pkg;

   // Default channel sample width.
   localparam int SAMPLE_BITS_DEFAULT = 8;

   // Operation codes carried with each request; code 3 is unused and ignored.
   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_MEASURE = 2'd1,
      OP_STRETCH = 2'd2
   } op_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_DRAIN  = 2'd2
   } state_type;

   // Commands from the sequencer to every channel lane.
   typedef struct packed {
      logic clear;
      logic measure;
      logic load;
      logic step;
   } lane_cmd_type;

endpackage

`default_nettype wire

@@ sv/rgb_contrast_stretch_top.sv @@
// Top level of the RGB contrast stretch block: three channel lanes and their sequencer.
// Clear and measure transactions produce no result.
// A stretch transaction runs SAMPLE_BITS divider steps in every lane (the restoring divider),
// then merges the lane results into the output register once that register is free; no new
// request is accepted until the stretch has left the drain state.
// Synchronous reset sets each minimum to full scale, each maximum to zero, and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module rgb_contrast_stretch_top #(
   parameter int SAMPLE_BITS = rcs_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_operation,
   input  wire logic [SAMPLE_BITS-1:0]   req_blue_in,
   input  wire logic [SAMPLE_BITS-1:0]   req_green_in,
   input  wire logic [SAMPLE_BITS-1:0]   req_red_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic      [SAMPLE_BITS-1:0]   rsp_blue_out,
   output logic      [SAMPLE_BITS-1:0]   rsp_green_out,
   output logic      [SAMPLE_BITS-1:0]   rsp_red_out
);

   // The sequencer issues the same command to every lane; each lane keeps its own
   // channel statistics and divides its own sample, so the three work side by side.
   rcs_pkg::lane_cmd_type  cmd;
   logic [SAMPLE_BITS-1:0] blue_res;
   logic [SAMPLE_BITS-1:0] green_res;
   logic [SAMPLE_BITS-1:0] red_res;

   rcs_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_blue (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sample (req_blue_in),
      .result (blue_res)
   );

   rcs_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_green (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sample (req_green_in),
      .result (green_res)
   );

   rcs_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_red (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sample (req_red_in),
      .result (red_res)
   );

   // The sequencer also merges the lane results into one response transaction, and the
   // output register lets a new transaction enter while a response still waits.
   rcs_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .cmd           (cmd),
      .blue_res      (blue_res),
      .green_res     (green_res),
      .red_res       (red_res),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out)
   );

endmodule

`default_nettype wire

@@ sv/rcs_lane.sv @@
// One channel lane: running minimum and maximum plus a restoring divider for the stretch.
`timescale 1ns / 1ps
`default_nettype none

module rcs_lane #(
   parameter int SAMPLE_BITS = rcs_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rcs_pkg::lane_cmd_type    cmd,
   input  wire logic [SAMPLE_BITS-1:0]   sample,
   output logic      [SAMPLE_BITS-1:0]   result
);

   localparam int W = SAMPLE_BITS;
   localparam logic [W-1:0] FULL = {W{1'b1}};

   logic [W-1:0]   low_ff, low_in;
   logic [W-1:0]   high_ff, high_in;
   logic [W-1:0]   rem_ff, rem_in;
   logic [W-1:0]   quo_ff, quo_in;
   logic [W-1:0]   div_ff, div_in;
   logic [W-1:0]   spec_val_ff, spec_val_in;
   logic           spec_ff, spec_in;

   logic [W-1:0]   offset;
   logic [2*W-1:0] numerator;
   logic [W:0]     shifted;
   logic [W+1:0]   trial;
   logic           fits;

   // Offset above the minimum, scaled by full scale as a shift and one subtract.
   assign offset    = sample - low_ff;
   assign numerator = {offset, {W{1'b0}}} - {{W{1'b0}}, offset};

   // One restoring step: bring down the next numerator bit and try the divisor.
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, div_ff};
   assign fits    = ~trial[W+1];

   always_comb begin
      low_in      = low_ff;
      high_in     = high_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      div_in      = div_ff;
      spec_in     = spec_ff;
      spec_val_in = spec_val_ff;
      if (cmd.clear) begin
         low_in  = FULL;
         high_in = '0;
      end
      if (cmd.measure) begin
         if (sample < low_ff) begin
            low_in = sample;
         end
         if (sample > high_ff) begin
            high_in = sample;
         end
      end
      if (cmd.load) begin
         rem_in = numerator[2*W-1:W];
         quo_in = numerator[W-1:0];
         div_in = high_ff - low_ff;
         priority if (high_ff <= low_ff) begin
            spec_in     = 1'b1;
            spec_val_in = '0;
         end else if (sample <= low_ff) begin
            spec_in     = 1'b1;
            spec_val_in = '0;
         end else if (sample >= high_ff) begin
            spec_in     = 1'b1;
            spec_val_in = FULL;
         end else begin
            spec_in     = 1'b0;
            spec_val_in = '0;
         end
      end
      if (cmd.step) begin
         rem_in = fits ? trial[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= FULL;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_ff      <= div_in;
      spec_ff     <= spec_in;
      spec_val_ff <= spec_val_in;
   end

   assign result = spec_ff ? spec_val_ff : quo_ff;

endmodule

`default_nettype wire

@@ sv/rcs_ctrl.sv @@
// Sequencer for the lanes and merging output register for the three channel results.
`timescale 1ns / 1ps
`default_nettype none

module rcs_ctrl #(
   parameter int SAMPLE_BITS = rcs_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_operation,
   output rcs_pkg::lane_cmd_type         cmd,
   input  wire logic [SAMPLE_BITS-1:0]   blue_res,
   input  wire logic [SAMPLE_BITS-1:0]   green_res,
   input  wire logic [SAMPLE_BITS-1:0]   red_res,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic      [SAMPLE_BITS-1:0]   rsp_blue_out,
   output logic      [SAMPLE_BITS-1:0]   rsp_green_out,
   output logic      [SAMPLE_BITS-1:0]   rsp_red_out
);

   localparam int CW = $clog2(SAMPLE_BITS);
   localparam logic [CW-1:0] LAST_STEP = CW'(SAMPLE_BITS - 1);

   rcs_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] blue_ff, blue_in, green_ff, green_in, red_ff, red_in;

   logic accept;
   logic out_free;
   logic load_out;
   rcs_pkg::op_type op;

   assign op       = rcs_pkg::op_type'(req_operation);
   assign accept   = req_valid && !req_stall;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign load_out = (state_ff == rcs_pkg::ST_DRAIN) && out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         rcs_pkg::ST_IDLE: begin
            if (accept && op == rcs_pkg::OP_STRETCH) begin
               state_in = rcs_pkg::ST_DIVIDE;
               cnt_in   = LAST_STEP;
            end
         end
         rcs_pkg::ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = rcs_pkg::ST_DRAIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         rcs_pkg::ST_DRAIN: begin
            if (out_free) begin
               state_in = rcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rcs_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs to the lanes and the request side.
   always_comb begin
      req_stall   = 1'b1;
      cmd.clear   = 1'b0;
      cmd.measure = 1'b0;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      unique case (state_ff)
         rcs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            unique case (op)
               rcs_pkg::OP_CLEAR:   cmd.clear   = req_valid;
               rcs_pkg::OP_MEASURE: cmd.measure = req_valid;
               rcs_pkg::OP_STRETCH: cmd.load    = req_valid;
               default: ;
            endcase
         end
         rcs_pkg::ST_DIVIDE: begin
            cmd.step = 1'b1;
         end
         default: ;
      endcase
   end

   // Merge the lane results into the output register.
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      blue_in      = blue_ff;
      green_in     = green_ff;
      red_in       = red_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         blue_in      = blue_res;
         green_in     = green_res;
         red_in       = red_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcs_pkg::ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blue_ff  <= blue_in;
      green_ff <= green_in;
      red_ff   <= red_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_green_out = green_ff;
   assign rsp_red_out   = red_ff;

endmodule

`default_nettype wire
